### hw/rtl/lbtc_pkg.sv
`timescale 1ns / 1ps

package lbtc_pkg;

  // payload field types
  typedef logic [1:0]  req_type_t;
  typedef logic [1:0]  status_t;
  typedef logic [31:0] block_key_t;
  typedef logic [5:0]  slot_fld_t;

  // request codes
  localparam req_type_t REQ_LOOKUP  = 2'd0;
  localparam req_type_t REQ_ALLOC   = 2'd1;
  localparam req_type_t REQ_RELEASE = 2'd2;

  // result status codes
  localparam status_t ST_OK       = 2'd0;
  localparam status_t ST_MISS     = 2'd1;
  localparam status_t ST_NULL_KEY = 2'd2;
  localparam status_t ST_NOT_USED = 2'd3;

  // null key after reset
  localparam block_key_t NULL_KEY_RST = 32'hFFFF_FFFF;

endpackage

### hw/rtl/lbtc_req_if.sv
`timescale 1ns / 1ps

interface lbtc_req_if;
  logic                   valid;
  logic                   ready;
  lbtc_pkg::req_type_t    req_type;
  lbtc_pkg::block_key_t   block_key;
  lbtc_pkg::slot_fld_t    slot_in;

  modport source (output valid, output req_type, output block_key, output slot_in,
                  input ready);
  modport sink   (input valid, input req_type, input block_key, input slot_in,
                  output ready);
endinterface

### hw/rtl/lbtc_rsp_if.sv
`timescale 1ns / 1ps

interface lbtc_rsp_if;
  logic                 valid;
  logic                 ready;
  lbtc_pkg::status_t    status;
  lbtc_pkg::slot_fld_t  slot_out;
  logic                 recycled;

  modport source (output valid, output status, output slot_out, output recycled,
                  input ready);
  modport sink   (input valid, input status, input slot_out, input recycled,
                  output ready);
endinterface

### hw/rtl/lru_block_tag_cache_top.sv
`timescale 1ns / 1ps
// Allocate takes a slot from the free list, or recycles the least recent one when none is free;
// lookup and release scan the recency list one entry a cycle from the most recent
// end and then shift the tail down one entry a cycle.
// Throughput: one request at a time, ready is high only in idle after the result
// has been loaded into the output register.
// Reset: after rst_ni the free list memory is filled, ready stays low
// meanwhile; null key resets to all ones, no slots in use.
module lru_block_tag_cache_top #(
  parameter int SLOTS = 64
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  lbtc_pkg::block_key_t  cfg_wdata_i,
  lbtc_req_if.sink              req_i,
  lbtc_rsp_if.source            rsp_o
);
  import lbtc_pkg::*;

  localparam int SW   = $clog2(SLOTS);
  localparam int CW   = $clog2(SLOTS + 1);
  localparam int CMPW = (SW > 6) ? SW : 6;

  typedef logic [SW-1:0] slot_t;
  typedef logic [CW-1:0] cnt_t;

  // recency entry carries the tag along with its slot
  typedef struct packed {
    block_key_t key;
    slot_t      slot;
  } rec_t;

  typedef enum logic [2:0] {
    S_INIT, S_IDLE, S_SCAN, S_SHIFT, S_TAIL, S_REFILL, S_RECYC, S_RESP
  } state_e;

  state_e     state_q;
  slot_t      init_q;
  cnt_t       used_q, free_q;
  slot_t      first_q, head_q;
  block_key_t null_key_q;
  req_type_t  req_q;
  block_key_t key_q;
  slot_fld_t  sin_q;
  slot_t      idx_q, dpos_q, tslot_q;
  logic       more_q, dvld_q, rotate_q;
  status_t    res_status_q;
  slot_fld_t  res_slot_q;
  logic       res_recyc_q;
  logic       out_vld_q;
  status_t    out_status_q;
  slot_fld_t  out_slot_q;
  logic       out_recyc_q;

  // memories
  rec_t  rec_mem [SLOTS];
  rec_t  rec_rd_q;
  slot_t rest_mem [SLOTS];
  slot_t rest_rd_q;

  logic  rec_re, rec_we, rest_re, rest_we;
  slot_t rec_ra, rec_wa, rest_ra, rest_wa, rest_wd;
  rec_t  rec_wd;

  logic  acc, match;
  cnt_t  used_m1;
  slot_t last_pos, head_inc, head_dec;

  assign req_i.ready    = (state_q == S_IDLE);
  assign acc            = req_i.valid && req_i.ready;
  assign rsp_o.valid    = out_vld_q;
  assign rsp_o.status   = out_status_q;
  assign rsp_o.slot_out = out_slot_q;
  assign rsp_o.recycled = out_recyc_q;

  assign used_m1  = cnt_t'(used_q - cnt_t'(1));
  assign last_pos = used_m1[SW-1:0];
  assign head_inc = (head_q == slot_t'(SLOTS - 1)) ? '0 : slot_t'(head_q + slot_t'(1));
  assign head_dec = (head_q == '0) ? slot_t'(SLOTS - 1) : slot_t'(head_q - slot_t'(1));

  // compare unit: tag for lookups, slot number for releases
  assign match = dvld_q && ((req_q == REQ_LOOKUP) ? (rec_rd_q.key == key_q)
                                                  : (CMPW'(rec_rd_q.slot) == CMPW'(sin_q)));

  // memory port control
  always_comb begin
    rec_re  = 1'b0;
    rec_ra  = idx_q;
    rec_we  = 1'b0;
    rec_wa  = slot_t'(dpos_q - slot_t'(1));
    rec_wd  = rec_rd_q;
    rest_re = 1'b0;
    rest_ra = head_q;
    rest_we = 1'b0;
    rest_wa = head_dec;
    rest_wd = rec_rd_q.slot;
    unique case (state_q)
      S_INIT: begin
        rest_we = 1'b1;
        rest_wa = init_q;
        rest_wd = slot_t'(slot_t'(SLOTS - 1) - init_q);
      end
      S_IDLE: begin
        if (acc && req_i.req_type == REQ_ALLOC) begin
          if (free_q != '0) begin
            rec_we  = 1'b1;
            rec_wa  = used_q[SW-1:0];
            rec_wd  = '{key: req_i.block_key, slot: first_q};
            rest_re = 1'b1;
          end else begin
            rec_re = 1'b1;
            rec_ra = '0;
          end
        end
      end
      S_SCAN: begin
        rec_re = more_q && !match;
        if (match && req_q == REQ_RELEASE && free_q != '0) begin
          rest_we = 1'b1;
        end
      end
      S_SHIFT: begin
        rec_re = more_q;
        rec_we = dvld_q;
      end
      S_TAIL: begin
        rec_we = rotate_q;
        rec_wa = last_pos;
        rec_wd = '{key: key_q, slot: tslot_q};
      end
      default: ;
    endcase
  end

  // recency memory, tag and slot per entry
  always_ff @(posedge clk_i) begin
    if (rec_we) begin
      rec_mem[rec_wa] <= rec_wd;
    end
    if (rec_re) begin
      rec_rd_q <= rec_mem[rec_ra];
    end
  end

  // free list memory, circular behind the cached first entry
  always_ff @(posedge clk_i) begin
    if (rest_we) begin
      rest_mem[rest_wa] <= rest_wd;
    end
    if (rest_re) begin
      rest_rd_q <= rest_mem[rest_ra];
    end
  end

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_INIT;
      init_q       <= '0;
      used_q       <= '0;
      free_q       <= cnt_t'(SLOTS);
      first_q      <= '0;
      head_q       <= '0;
      null_key_q   <= NULL_KEY_RST;
      req_q        <= REQ_LOOKUP;
      more_q       <= 1'b0;
      dvld_q       <= 1'b0;
      rotate_q     <= 1'b0;
      out_vld_q    <= 1'b0;
      key_q        <= '0;
      sin_q        <= '0;
      idx_q        <= '0;
      dpos_q       <= '0;
      tslot_q      <= '0;
      res_status_q <= ST_OK;
      res_slot_q   <= '0;
      res_recyc_q  <= 1'b0;
      out_status_q <= ST_OK;
      out_slot_q   <= '0;
      out_recyc_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        null_key_q <= cfg_wdata_i;
      end
      if (rsp_o.ready) begin
        out_vld_q <= 1'b0;
      end

      unique case (state_q)
        // fill free list: first is slot 0, then SLOTS-1 down to 1
        S_INIT: begin
          init_q <= slot_t'(init_q + slot_t'(1));
          if (init_q == slot_t'(SLOTS - 1)) begin
            state_q <= S_IDLE;
          end
        end

        S_IDLE: begin
          if (acc) begin
            req_q       <= req_i.req_type;
            key_q       <= req_i.block_key;
            sin_q       <= req_i.slot_in;
            more_q      <= 1'b1;
            dvld_q      <= 1'b0;
            idx_q       <= last_pos;
            res_recyc_q <= 1'b0;
            res_slot_q  <= '0;
            res_status_q <= ST_OK;
            state_q     <= S_RESP;
            unique case (req_i.req_type)
              REQ_LOOKUP: begin
                res_status_q <= ST_MISS;
                if (req_i.block_key == null_key_q) begin
                  res_status_q <= ST_NULL_KEY;
                end else if (used_q != '0) begin
                  state_q <= S_SCAN;
                end
              end
              REQ_ALLOC: begin
                if (free_q != '0) begin
                  res_slot_q <= slot_fld_t'(first_q);
                  used_q     <= cnt_t'(used_q + cnt_t'(1));
                  free_q     <= cnt_t'(free_q - cnt_t'(1));
                  if (free_q > cnt_t'(1)) begin
                    state_q <= S_REFILL;
                  end
                end else if (used_q != '0) begin
                  res_recyc_q <= 1'b1;
                  state_q     <= S_RECYC;
                end else begin
                  res_status_q <= ST_MISS;
                end
              end
              REQ_RELEASE: begin
                res_slot_q   <= req_i.slot_in;
                res_status_q <= ST_NOT_USED;
                if (used_q != '0) begin
                  state_q <= S_SCAN;
                end
              end
              default: ;
            endcase
          end
        end

        // search from most recent down, one entry a cycle
        S_SCAN: begin
          if (more_q && !match) begin
            dvld_q <= 1'b1;
            dpos_q <= idx_q;
            if (idx_q == '0) begin
              more_q <= 1'b0;
            end else begin
              idx_q <= slot_t'(idx_q - slot_t'(1));
            end
          end else begin
            dvld_q <= 1'b0;
          end
          if (match) begin
            tslot_q      <= rec_rd_q.slot;
            res_status_q <= ST_OK;
            rotate_q     <= (req_q == REQ_LOOKUP);
            if (req_q == REQ_LOOKUP) begin
              res_slot_q <= slot_fld_t'(rec_rd_q.slot);
            end else begin
              // put released slot just after the first free one
              free_q <= cnt_t'(free_q + cnt_t'(1));
              if (free_q == '0) begin
                first_q <= rec_rd_q.slot;
              end else begin
                head_q <= head_dec;
              end
            end
            if (dpos_q == last_pos) begin
              state_q <= S_TAIL;
            end else begin
              idx_q   <= slot_t'(dpos_q + slot_t'(1));
              more_q  <= 1'b1;
              dvld_q  <= 1'b0;
              state_q <= S_SHIFT;
            end
          end else if (dvld_q && dpos_q == '0) begin
            state_q <= S_RESP;
          end
        end

        // least recent slot is evicted and rotated to the end
        S_RECYC: begin
          tslot_q    <= rec_rd_q.slot;
          res_slot_q <= slot_fld_t'(rec_rd_q.slot);
          rotate_q   <= 1'b1;
          if (last_pos == '0) begin
            state_q <= S_TAIL;
          end else begin
            idx_q   <= slot_t'(1);
            more_q  <= 1'b1;
            dvld_q  <= 1'b0;
            state_q <= S_SHIFT;
          end
        end

        // close the gap: read one entry up, write it one down
        S_SHIFT: begin
          if (more_q) begin
            dvld_q <= 1'b1;
            dpos_q <= idx_q;
            if (idx_q == last_pos) begin
              more_q <= 1'b0;
            end else begin
              idx_q <= slot_t'(idx_q + slot_t'(1));
            end
          end else begin
            dvld_q <= 1'b0;
          end
          if (dvld_q && dpos_q == last_pos) begin
            state_q <= S_TAIL;
          end
        end

        // rotate writes the most recent entry, removal shrinks the list
        S_TAIL: begin
          if (!rotate_q) begin
            used_q <= used_m1;
          end
          state_q <= S_RESP;
        end

        // next free slot moves into the cached first entry
        S_REFILL: begin
          first_q <= rest_rd_q;
          head_q  <= head_inc;
          state_q <= S_RESP;
        end

        // result into the output register
        S_RESP: begin
          if (!out_vld_q || rsp_o.ready) begin
            out_vld_q    <= 1'b1;
            out_status_q <= res_status_q;
            out_slot_q   <= res_slot_q;
            out_recyc_q  <= res_recyc_q;
            state_q      <= S_IDLE;
          end
        end

        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

### bench/tb_lru_block_tag_cache_top.sv
`timescale 1ns / 1ps

module tb_lru_block_tag_cache_top;
  import lbtc_pkg::*;

  localparam int        SLOTS      = 64;
  localparam int        IDLE_LIMIT = 4000;
  localparam int        TAIL_WAIT  = 200;
  localparam req_type_t REQ_UNUSED = 2'd3;

  // one expected response beat
  typedef struct packed {
    status_t   status;
    slot_fld_t slot;
    logic      recycled;
  } tag_rsp_t;

  logic       clk_i;
  logic       rst_ni;
  logic       cfg_we_i;
  block_key_t cfg_wdata_i;

  lbtc_req_if req_bus ();
  lbtc_rsp_if rsp_bus ();

  lru_block_tag_cache_top #(
    .SLOTS(SLOTS)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .req_i      (req_bus),
    .rsp_o      (rsp_bus)
  );

  // tag store mirror
  block_key_t tag_mem [SLOTS];
  bit         slot_busy [SLOTS];
  slot_fld_t  recency_q [$];
  slot_fld_t  free_q [$];
  block_key_t null_key_m;

  tag_rsp_t   tag_results_q [$];
  block_key_t key_pool [16];

  int mismatch_cnt = 0;
  int rsp_seen     = 0;
  int burst_left;
  int quiet_cycles = 0;

  // receiver stall pattern
  logic [15:0] stall_pat  = 16'h0001;
  logic [3:0]  stall_idx  = '0;
  bit          stall_free = 1'b0;
  int          stall_cyc  = 0;

  // clock
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic void reset_tag_model();
    int i;
    null_key_m = NULL_KEY_RST;
    recency_q.delete();
    free_q.delete();
    free_q.push_back(slot_fld_t'(0));
    for (i = 1; i < SLOTS; i++) free_q.push_back(slot_fld_t'(SLOTS - i));
    for (i = 0; i < SLOTS; i++) begin
      slot_busy[i] = 1'b0;
      tag_mem[i]   = '0;
    end
  endfunction

  // apply one request to the mirror and return the response it should give
  function automatic tag_rsp_t apply_tag_request(req_type_t rt, block_key_t key,
                                                 slot_fld_t sl);
    tag_rsp_t  r;
    slot_fld_t s;
    bit        got;
    int        i;
    r   = '{status: ST_OK, slot: '0, recycled: 1'b0};
    got = 1'b0;
    case (rt)
      REQ_LOOKUP: begin
        if (key == null_key_m) begin
          r.status = ST_NULL_KEY;
        end else begin
          r.status = ST_MISS;
          // newest copy of a duplicated tag wins
          for (i = recency_q.size() - 1; i >= 0; i--) begin
            if (tag_mem[recency_q[i]] == key) begin
              s = recency_q[i];
              recency_q.delete(i);
              recency_q.push_back(s);
              r.status = ST_OK;
              r.slot   = s;
              break;
            end
          end
        end
      end
      REQ_ALLOC: begin
        if (free_q.size() > 0) begin
          s   = free_q.pop_front();
          got = 1'b1;
        end else if (recency_q.size() > 0) begin
          // evict least recent, its old tag is dropped
          s          = recency_q.pop_front();
          r.recycled = 1'b1;
          got        = 1'b1;
        end else begin
          r.status = ST_MISS;
        end
        if (got) begin
          slot_busy[s] = 1'b1;
          tag_mem[s]   = key;
          recency_q.push_back(s);
          r.slot = s;
        end
      end
      REQ_RELEASE: begin
        r.slot = sl;
        if (!slot_busy[sl]) begin
          r.status = ST_NOT_USED;
        end else begin
          for (i = 0; i < recency_q.size(); i++) begin
            if (recency_q[i] == sl) begin
              recency_q.delete(i);
              break;
            end
          end
          slot_busy[sl] = 1'b0;
          tag_mem[sl]   = null_key_m;
          // goes right behind the first free slot
          if (free_q.size() == 0) free_q.push_back(sl);
          else free_q.insert(1, sl);
        end
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch on response %0d: %s", $time, rsp_seen, what);
    mismatch_cnt++;
  endtask

  // send one request beat, bursts with random gaps in between
  task automatic send_req(input req_type_t rt, input block_key_t key, input slot_fld_t sl);
    int r;
    int gap;
    if (burst_left == 0) begin
      req_bus.valid <= 1'b0;
      r = $urandom_range(0, 99);
      if (r < 60) gap = $urandom_range(1, 3);
      else if (r < 90) gap = $urandom_range(4, 20);
      else gap = $urandom_range(21, 150);
      repeat (gap) @(posedge clk_i);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                                : $urandom_range(1, 8);
    end
    req_bus.valid     <= 1'b1;
    req_bus.req_type  <= rt;
    req_bus.block_key <= key;
    req_bus.slot_in   <= sl;
    do @(posedge clk_i); while (!req_bus.ready);
    tag_results_q.push_back(apply_tag_request(rt, key, sl));
    burst_left--;
  endtask

  // hold the sender until every pending response has come back
  task automatic wait_drained();
    req_bus.valid <= 1'b0;
    burst_left = 0;
    while (tag_results_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic set_null_key(input block_key_t v);
    wait_drained();
    repeat (4) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    null_key_m = v;
  endtask

  function automatic slot_fld_t pick_busy_slot();
    return recency_q[$urandom_range(0, recency_q.size() - 1)];
  endfunction

  // corner cases with the null key at its reset value
  task automatic test_reset_state();
    send_req(REQ_LOOKUP, 32'hFFFF_FFFF, '0);
    send_req(REQ_LOOKUP, 32'h0, '0);
    send_req(REQ_RELEASE, '0, 6'd5);
    send_req(REQ_UNUSED, '0, '0);
    send_req(REQ_ALLOC, 32'h0, '0);
    send_req(REQ_ALLOC, 32'hFFFF_FFFE, '0);
    send_req(REQ_ALLOC, 32'hFFFF_FFFF, '0);
    send_req(REQ_LOOKUP, 32'hFFFF_FFFF, '0);
    send_req(REQ_ALLOC, 32'h0, '0);
    send_req(REQ_LOOKUP, 32'h0, '0);
    send_req(REQ_LOOKUP, 32'hFFFF_FFFE, '0);
    send_req(REQ_RELEASE, '0, 6'd63);
    send_req(REQ_RELEASE, '0, 6'd63);
    send_req(REQ_LOOKUP, 32'hFFFF_FFFE, '0);
    send_req(REQ_ALLOC, 32'h1234_5678, '0);
    send_req(REQ_ALLOC, 32'hA5A5_A5A5, '0);
    send_req(REQ_RELEASE, '0, 6'd0);
    send_req(REQ_RELEASE, '0, 6'd0);
    send_req(REQ_LOOKUP, 32'h1234_5678, 6'd63);
    send_req(REQ_UNUSED, 32'hFFFF_FFFF, 6'd63);
  endtask

  // run the free list dry, recycle, release while full
  task automatic test_fill_and_recycle();
    int i;
    set_null_key(32'h0);
    for (i = 0; i < 75; i++) begin
      send_req(REQ_ALLOC, $urandom, slot_fld_t'($urandom));
      if (i % 7 == 3) send_req(REQ_LOOKUP, tag_mem[pick_busy_slot()], '0);
    end
    send_req(REQ_LOOKUP, tag_mem[recency_q[0]], '0);
    send_req(REQ_RELEASE, '0, recency_q[3]);
    send_req(REQ_RELEASE, '0, recency_q[10]);
    send_req(REQ_ALLOC, 32'h0, '0);
    send_req(REQ_ALLOC, $urandom, '0);
    send_req(REQ_ALLOC, $urandom, '0);
    send_req(REQ_LOOKUP, 32'h0, '0);
  endtask

  // random mix of requests, keys mostly drawn from stored tags and a small pool
  task automatic test_random_mix(input int n, input int alloc_pct, input int rel_pct,
                                 input int pause_at);
    int         i;
    int         r;
    int         k;
    req_type_t  rt;
    block_key_t key;
    slot_fld_t  sl;
    for (i = 0; i < 16; i++) key_pool[i] = $urandom;
    for (i = 0; i < n; i++) begin
      if (i == pause_at) wait_drained();
      r   = $urandom_range(0, 99);
      k   = $urandom_range(0, 99);
      key = $urandom;
      sl  = slot_fld_t'($urandom);
      if (r < alloc_pct) begin
        rt = REQ_ALLOC;
        if (k < 10) key = null_key_m;
        else if (k < 60) key = key_pool[$urandom_range(0, 15)];
      end else if (r < alloc_pct + rel_pct) begin
        rt = REQ_RELEASE;
        if (k < 75 && recency_q.size() > 0) sl = pick_busy_slot();
      end else if (r < 96) begin
        rt = REQ_LOOKUP;
        if (k < 55 && recency_q.size() > 0) key = tag_mem[pick_busy_slot()];
        else if (k < 65) key = null_key_m;
        else if (k < 85) key = key_pool[$urandom_range(0, 15)];
      end else begin
        rt = REQ_UNUSED;
      end
      send_req(rt, key, sl);
    end
  endtask

  // response checking and receiver stalls
  always @(posedge clk_i) begin : rsp_side
    tag_rsp_t want;
    if (rst_ni && rsp_bus.valid && rsp_bus.ready) begin
      if (tag_results_q.size() == 0) begin
        report_mismatch("response beat with nothing pending");
      end else begin
        want = tag_results_q.pop_front();
        if (rsp_bus.status !== want.status)
          report_mismatch($sformatf("status got %0d want %0d", rsp_bus.status,
                                    want.status));
        if (rsp_bus.slot_out !== want.slot)
          report_mismatch($sformatf("slot_out got %0d want %0d", rsp_bus.slot_out,
                                    want.slot));
        if (rsp_bus.recycled !== want.recycled)
          report_mismatch($sformatf("recycled got %0b want %0b", rsp_bus.recycled,
                                    want.recycled));
      end
      rsp_seen++;
    end
    if (stall_cyc == 0) begin
      stall_free = ($urandom_range(0, 3) == 0);
      stall_pat  = 16'($urandom) | 16'h0001;
      stall_cyc  = 128;
    end
    stall_cyc--;
    rsp_bus.ready <= stall_free | stall_pat[stall_idx];
    stall_idx++;
  end

  // watchdog on cycles with no beat on either side
  always @(posedge clk_i) begin
    if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= IDLE_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // test sequence
  initial begin
    burst_left   = 0;
    reset_tag_model();
    rst_ni            <= 1'b0;
    cfg_we_i          <= 1'b0;
    cfg_wdata_i       <= '0;
    req_bus.valid     <= 1'b0;
    req_bus.req_type  <= REQ_LOOKUP;
    req_bus.block_key <= '0;
    req_bus.slot_in   <= '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_reset_state();
    test_fill_and_recycle();
    set_null_key($urandom);
    test_random_mix(260, 45, 25, 150);
    set_null_key(32'hFFFF_FFFF);
    test_random_mix(260, 30, 40, -1);
    set_null_key(32'h0);
    test_random_mix(220, 50, 15, -1);

    wait_drained();
    repeat (TAIL_WAIT) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

### filelist.f
hw/rtl/lbtc_pkg.sv
hw/rtl/lbtc_req_if.sv
hw/rtl/lbtc_rsp_if.sv
hw/rtl/lru_block_tag_cache_top.sv
bench/tb_lru_block_tag_cache_top.sv
